// ----- design/fbd_pkg.sv -----
// fbd_pkg: shared widths, defaults and controller/datapath interface types
`default_nettype none
package fbd_pkg;

   localparam int CLOCK_W         = 28;
   localparam int BAUD_W          = 24;
   localparam int B16_W           = BAUD_W + 4;
   localparam int MUL_W           = 4;
   localparam int DIV_W           = 16;
   localparam int NUM_W           = 33;
   localparam int PROD_W          = 32;
   localparam int Q_W             = 28;
   localparam int S_W             = MUL_W + 1;
   localparam int CNT_W           = 6;
   localparam int MAX_MUL_DEFAULT = 15;

   typedef struct packed {
      logic load;
      logic p1_start;
      logic p1_eval;
      logic m_inc;
      logic p2_init;
      logic p2_start;
      logic p2_eval;
      logic a_inc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic b16_zero;
      logic div_done;
      logic better;
      logic exact;
      logic m_last;
      logic a_last;
   } status_type;

endpackage
`default_nettype wire

// ----- design/fbd_div.sv -----
// fbd_div: restoring divider, one quotient bit per cycle
`default_nettype none
module fbd_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [fbd_pkg::NUM_W-1:0]  num,
   input  wire logic [fbd_pkg::B16_W-1:0]  den,
   output logic                            done,
   output logic [fbd_pkg::NUM_W-1:0]       quot,
   output logic [fbd_pkg::B16_W-1:0]       rem
);
   import fbd_pkg::*;

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [B16_W-1:0] rem_ff, rem_in;
   logic [B16_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [B16_W:0]   trial;
   logic             ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? B16_W'(trial - {1'b0, den_ff}) : trial[B16_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ----- design/fbd_dp.sv -----
// fbd_dp: operand registers, error scoring, best-candidate tracking, result register
`default_nettype none
module fbd_dp #(
   parameter int MAX_MULTIPLIER = fbd_pkg::MAX_MUL_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fbd_pkg::cmd_type             cmd,
   output fbd_pkg::status_type               status,
   input  wire logic [fbd_pkg::CLOCK_W-1:0]  req_clock_hz,
   input  wire logic [fbd_pkg::BAUD_W-1:0]   req_baud_rate,
   output logic [fbd_pkg::MUL_W-1:0]         rsp_frac_multiplier,
   output logic [fbd_pkg::MUL_W-1:0]         rsp_frac_add,
   output logic [fbd_pkg::DIV_W-1:0]         rsp_divisor
);
   import fbd_pkg::*;

   logic [CLOCK_W-1:0] clk_ff, clk_in;
   logic [B16_W-1:0]   b16_ff, b16_in;
   logic [MUL_W-1:0]   m_ff, m_in;
   logic [MUL_W-1:0]   a_ff, a_in;
   logic [MUL_W-1:0]   best_mul_ff, best_mul_in;
   logic [MUL_W-1:0]   best_add_ff, best_add_in;
   logic [B16_W-1:0]   best_err_ff, best_err_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic [DIV_W-1:0]   dl0_ff, dl0_in;
   logic [DIV_W-1:0]   dlf_ff, dlf_in;
   logic               phase_ff, phase_in;
   logic [MUL_W-1:0]   out_mul_ff, out_mul_in;
   logic [MUL_W-1:0]   out_add_ff, out_add_in;
   logic [DIV_W-1:0]   out_div_ff, out_div_in;

   logic [PROD_W-1:0]  prod;
   logic [S_W-1:0]     s;
   logic [NUM_W-1:0]   div_num;
   logic [B16_W-1:0]   div_den;
   logic               div_start;
   logic               div_done;
   logic [NUM_W-1:0]   div_quot;
   logic [B16_W-1:0]   div_rem;
   logic [B16_W-1:0]   half;
   logic [B16_W-1:0]   err;

   assign prod      = PROD_W'(clk_ff) * PROD_W'(m_ff);
   assign s         = S_W'(best_mul_ff) + S_W'(a_ff);
   assign div_start = cmd.p1_start | cmd.p2_start;
   assign div_num   = cmd.p2_start ? NUM_W'(q_ff) + NUM_W'(s[S_W-1:1])
                                   : NUM_W'(prod) + NUM_W'(b16_ff[B16_W-1:1]);
   assign div_den   = cmd.p2_start ? B16_W'(s) : b16_ff;

   fbd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // rounded-quotient error reduces to |half divisor - remainder|
   assign half = phase_ff ? B16_W'(s[S_W-1:1]) : B16_W'(b16_ff[B16_W-1:1]);
   assign err  = (half >= div_rem) ? half - div_rem : div_rem - half;

   assign status.b16_zero = (b16_ff == '0);
   assign status.div_done = div_done;
   assign status.better   = (err < best_err_ff);
   assign status.exact    = (err == '0);
   assign status.m_last   = (m_ff == MUL_W'(MAX_MULTIPLIER));
   assign status.a_last   = (a_ff == best_mul_ff - MUL_W'(1));

   always_comb begin
      clk_in      = clk_ff;
      b16_in      = b16_ff;
      m_in        = m_ff;
      a_in        = a_ff;
      best_mul_in = best_mul_ff;
      best_add_in = best_add_ff;
      best_err_in = best_err_ff;
      q_in        = q_ff;
      dl0_in      = dl0_ff;
      dlf_in      = dlf_ff;
      phase_in    = phase_ff;
      out_mul_in  = out_mul_ff;
      out_add_in  = out_add_ff;
      out_div_in  = out_div_ff;
      if (cmd.load) begin
         clk_in      = req_clock_hz;
         b16_in      = {req_baud_rate, 4'b0000};
         m_in        = MUL_W'(1);
         best_mul_in = MUL_W'(1);
         best_err_in = '1;
         phase_in    = 1'b0;
      end
      if (cmd.p1_eval && status.better) begin
         best_err_in = err;
         best_mul_in = m_ff;
         q_in        = div_quot[Q_W-1:0];
      end
      if (cmd.p1_eval && m_ff == MUL_W'(1)) begin
         dl0_in = div_quot[DIV_W-1:0];
      end
      if (cmd.m_inc) begin
         m_in = m_ff + MUL_W'(1);
      end
      if (cmd.p2_init) begin
         phase_in    = 1'b1;
         a_in        = '0;
         best_add_in = '0;
         best_err_in = '1;
      end
      if (cmd.p2_eval && status.better) begin
         best_err_in = err;
         best_add_in = a_ff;
         dlf_in      = div_quot[DIV_W-1:0];
      end
      if (cmd.a_inc) begin
         a_in = a_ff + MUL_W'(1);
      end
      if (cmd.out_load) begin
         if (status.b16_zero) begin
            out_mul_in = MUL_W'(1);
            out_add_in = '0;
            out_div_in = '1;
         end else if (best_add_ff == '0) begin
            out_mul_in = MUL_W'(1);
            out_add_in = '0;
            out_div_in = dl0_ff;
         end else begin
            out_mul_in = best_mul_ff;
            out_add_in = best_add_ff;
            out_div_in = dlf_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      clk_in_hold: begin
         clk_ff      <= clk_in;
         b16_ff      <= b16_in;
         m_ff        <= m_in;
         a_ff        <= a_in;
         best_mul_ff <= best_mul_in;
         best_add_ff <= best_add_in;
         best_err_ff <= best_err_in;
         q_ff        <= q_in;
         dl0_ff      <= dl0_in;
         dlf_ff      <= dlf_in;
         out_mul_ff  <= out_mul_in;
         out_add_ff  <= out_add_in;
         out_div_ff  <= out_div_in;
      end
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign rsp_frac_multiplier = out_mul_ff;
   assign rsp_frac_add        = out_add_ff;
   assign rsp_divisor         = out_div_ff;

endmodule
`default_nettype wire

// ----- design/fbd_ctrl.sv -----
// fbd_ctrl: sequencer for the multiplier and add-value searches and the result handshake
`default_nettype none
module fbd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output fbd_pkg::cmd_type          cmd,
   input  wire fbd_pkg::status_type  status
);
   import fbd_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CHECK    = 3'd1;
   localparam logic [2:0] S_P1_START = 3'd2;
   localparam logic [2:0] S_P1_WAIT  = 3'd3;
   localparam logic [2:0] S_P2_INIT  = 3'd4;
   localparam logic [2:0] S_P2_START = 3'd5;
   localparam logic [2:0] S_P2_WAIT  = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       stop;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign stop      = status.better && status.exact;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = status.b16_zero ? S_FINISH : S_P1_START;
         end
         S_P1_START: begin
            cmd.p1_start = 1'b1;
            state_in     = S_P1_WAIT;
         end
         S_P1_WAIT: begin
            if (status.div_done) begin
               cmd.p1_eval = 1'b1;
               if (stop || status.m_last) begin
                  state_in = S_P2_INIT;
               end else begin
                  cmd.m_inc = 1'b1;
                  state_in  = S_P1_START;
               end
            end
         end
         S_P2_INIT: begin
            cmd.p2_init = 1'b1;
            state_in    = S_P2_START;
         end
         S_P2_START: begin
            cmd.p2_start = 1'b1;
            state_in     = S_P2_WAIT;
         end
         S_P2_WAIT: begin
            if (status.div_done) begin
               cmd.p2_eval = 1'b1;
               if (stop || status.a_last) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.a_inc = 1'b1;
                  state_in  = S_P2_START;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/fractional_baud_divider_search.sv -----
// fractional_baud_divider_search: top level, fractional baud divider search
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_clock_hz, req_baud_rate
//   rsp      out        rsp_valid / rsp_stall  rsp_frac_multiplier, rsp_frac_add, rsp_divisor
//
// one item at a time; every division runs on the shared bit-serial divider
// an item with a zero baud rate skips the searches; otherwise it runs
// up to 15 multiplier trials and up to 15 add-value trials, one division each
// reset is synchronous and clears the sequencer and the result valid
// the next item is taken while a finished result waits under rsp_stall
`default_nettype none
module fractional_baud_divider_search #(
   parameter int MAX_MULTIPLIER = fbd_pkg::MAX_MUL_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [fbd_pkg::CLOCK_W-1:0]  req_clock_hz,
   input  wire logic [fbd_pkg::BAUD_W-1:0]   req_baud_rate,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [fbd_pkg::MUL_W-1:0]         rsp_frac_multiplier,
   output logic [fbd_pkg::MUL_W-1:0]         rsp_frac_add,
   output logic [fbd_pkg::DIV_W-1:0]         rsp_divisor
);
   import fbd_pkg::*;

   cmd_type    cmd;
   status_type status;

   fbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   fbd_dp #(
      .MAX_MULTIPLIER (MAX_MULTIPLIER)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_clock_hz        (req_clock_hz),
      .req_baud_rate       (req_baud_rate),
      .rsp_frac_multiplier (rsp_frac_multiplier),
      .rsp_frac_add        (rsp_frac_add),
      .rsp_divisor         (rsp_divisor)
   );

endmodule
`default_nettype wire

// ----- design/fbd_checker.sv -----
// fbd_checker: port-level assertions for the fractional baud divider search, with bind
`default_nettype none
module fbd_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [fbd_pkg::MUL_W-1:0]    rsp_frac_multiplier,
   input wire logic [fbd_pkg::MUL_W-1:0]    rsp_frac_add,
   input wire logic [fbd_pkg::DIV_W-1:0]    rsp_divisor
);
   import fbd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frac_multiplier)
         && $stable(rsp_frac_add) && $stable(rsp_divisor))
      else $error("stalled result item changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   a_add_below_mul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frac_multiplier != '0 && rsp_frac_add < rsp_frac_multiplier)
      else $error("add value not below multiplier");

   a_no_frac_mul_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frac_add == '0 |-> rsp_frac_multiplier == MUL_W'(1))
      else $error("multiplier not 1 without fraction");

endmodule

bind fractional_baud_divider_search fbd_checker u_fbd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_frac_multiplier (rsp_frac_multiplier),
   .rsp_frac_add        (rsp_frac_add),
   .rsp_divisor         (rsp_divisor)
);
`default_nettype wire
